/* hw/rtl/tlvmp_pkg.sv */
// ----------------------------------------------------------------------------
// tlvmp_pkg
// Types, constants and helpers shared by the TLV MAC record parser.
// ----------------------------------------------------------------------------
package tlvmp_pkg;

  localparam int unsigned DefaultLengthWidth = 12;

  localparam logic [7:0] KeyBase      = 8'h22;
  localparam logic [7:0] AsciiZero    = 8'h30;
  localparam logic [7:0] AsciiColon   = 8'h3a;
  localparam logic [7:0] AsciiUpperA  = 8'h41;
  localparam logic [7:0] AsciiUpperF  = 8'h46;
  localparam logic [7:0] HexAlphaBias = 8'h37;

  localparam logic [2:0] MacPairs = 3'd6;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_KEY       = 3'd1,
    PH_LEN_MATCH = 3'd2,
    PH_LEN_SKIP  = 3'd3,
    PH_SKIP      = 3'd4,
    PH_MAC       = 3'd5,
    PH_DONE      = 3'd6
  } tlvmp_phase_e;

  // Parser context that does not depend on the length width
  typedef struct packed {
    tlvmp_phase_e phase;
    logic [7:0]   rem;
    logic [47:0]  mac;
    logic [2:0]   pair;
    logic [1:0]   cig;
    logic [3:0]   hn;
  } tlvmp_ctx_t;

  typedef struct packed {
    logic        valid;
    logic        found;
    logic [47:0] mac;
  } tlvmp_res_t;

  localparam tlvmp_ctx_t CtxReset = '{
    phase: PH_HEADER,
    rem:   8'd0,
    mac:   48'd0,
    pair:  3'd0,
    cig:   2'd0,
    hn:    4'd0
  };

  // ASCII hex digit to value; anything else (lowercase too) is zero
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'd0;
      if (c >= AsciiZero && c < AsciiColon) begin
        t = c - AsciiZero;
      end else if (c >= AsciiUpperA && c <= AsciiUpperF) begin
        t = c - HexAlphaBias;
      end
      return t[3:0];
    end
  endfunction

  // Byte lane of a pair index, modulo the six pairs
  function automatic logic [2:0] mac_lane(input logic [2:0] pair);
    begin
      return (pair >= MacPairs) ? (pair - MacPairs) : pair;
    end
  endfunction

endpackage

/* hw/rtl/tlv_mac_record_parser.sv */
// ----------------------------------------------------------------------------
// tlv_mac_record_parser
// Byte-serial search for a network MAC record in a card-info TLV payload.
// ----------------------------------------------------------------------------
// Each byte is held in the input register until the result register has room, then its result is registered there.
// Throughput: one byte per cycle while the consumer does not stall the result register.
// At most one result per payload; bytes after it are dropped until start.
// Reset: async active low; parser starts in header phase, mac_slot = 0.
module tlv_mac_record_parser import tlvmp_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = DefaultLengthWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  payload_byte_i,
  input  logic        payload_start_i,
  input  logic        payload_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [47:0] mac_address_o
);

  logic [1:0] mac_slot_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       start_q;
  logic       end_q;
  logic       in_accept;

  tlvmp_ctx_t              ctx_q, ctx_d;
  logic [LENGTH_WIDTH-1:0] pos_q, pos_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  tlvmp_res_t              res;
  logic                    out_free;
  logic                    advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_slot_q <= 2'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mac_slot_q <= cfg_data_i;
    end
  end

  // input register: the held request moves on when the result side has room
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= payload_byte_i;
      start_q <= payload_start_i;
      end_q   <= payload_end_i;
    end
  end

  tlvmp_step #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .ctx_i           (ctx_q),
    .pos_i           (pos_q),
    .len_i           (len_q),
    .payload_byte_i  (byte_q),
    .payload_start_i (start_q),
    .payload_end_i   (end_q),
    .mac_slot_i      (mac_slot_q),
    .ctx_o           (ctx_d),
    .pos_o           (pos_d),
    .len_o           (len_d),
    .res_o           (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q <= CtxReset;
      pos_q <= '0;
      len_q <= '0;
    end else if (advance) begin
      ctx_q <= ctx_d;
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

  tlvmp_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (advance && res.valid),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .mac_address_o (mac_address_o)
  );

  // a not-found result carries a zero address
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (mac_address_o == 48'd0))
    else $error("not-found result with nonzero address");

  // once a result is produced the parser sits in the done phase
  a_done_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |=> (ctx_q.phase == PH_DONE))
    else $error("parser not done after result");

  // input is only held off while the input register is occupied
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("stall with empty input register");

  // decode never runs past the sixth pair
  a_pair_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctx_q.phase == PH_MAC) |-> (ctx_q.pair < MacPairs))
    else $error("pair index out of range in decode");

endmodule

/* hw/rtl/tlvmp_step.sv */
// ----------------------------------------------------------------------------
// tlvmp_step
// Per-byte next-state logic of the parser: header, record walk, hex decode.
// ----------------------------------------------------------------------------
module tlvmp_step import tlvmp_pkg::*; #(
  parameter int unsigned LENGTH_WIDTH = DefaultLengthWidth
) (
  input  tlvmp_ctx_t              ctx_i,
  input  logic [LENGTH_WIDTH-1:0] pos_i,
  input  logic [LENGTH_WIDTH-1:0] len_i,
  input  logic [7:0]              payload_byte_i,
  input  logic                    payload_start_i,
  input  logic                    payload_end_i,
  input  logic [1:0]              mac_slot_i,
  output tlvmp_ctx_t              ctx_o,
  output logic [LENGTH_WIDTH-1:0] pos_o,
  output logic [LENGTH_WIDTH-1:0] len_o,
  output tlvmp_res_t              res_o
);

  localparam logic [LENGTH_WIDTH-1:0] PosMax = {LENGTH_WIDTH{1'b1}};

  tlvmp_ctx_t              ctx_c;
  logic [LENGTH_WIDTH-1:0] pos_c;
  logic [LENGTH_WIDTH-1:0] len_c;
  logic [7:0]              b;
  logic [15:0]             len_ext;
  logic [7:0]              rem_dec;
  logic [2:0]              pair_inc;
  logic [7:0]              pair_val;
  logic [47:0]             end_mac;
  logic                    give;
  logic                    give_found;
  logic [47:0]             give_mac;

  always_comb begin
    ctx_c = payload_start_i ? CtxReset : ctx_i;
    pos_c = payload_start_i ? '0 : pos_i;
    len_c = payload_start_i ? '0 : len_i;

    ctx_o      = ctx_c;
    pos_o      = pos_c;
    len_o      = len_c;
    res_o      = '0;
    b          = payload_byte_i;
    len_ext    = 16'(len_c);
    rem_dec    = ctx_c.rem - 8'd1;
    pair_inc   = ctx_c.pair + 3'd1;
    pair_val   = {ctx_c.hn, hex_value(b)};
    end_mac    = '0;
    give       = 1'b0;
    give_found = 1'b0;
    give_mac   = '0;

    if (ctx_c.phase != PH_DONE) begin
      // outside the header, bytes at or past the payload length read as zero
      if (ctx_c.phase != PH_HEADER && pos_c >= len_c) begin
        b = 8'd0;
      end
      pair_val = {ctx_c.hn, hex_value(b)};

      case (ctx_c.phase)
        PH_HEADER: begin
          if (pos_c == '0) begin
            len_ext = len_ext | 16'(b);
          end else if (pos_c == LENGTH_WIDTH'(1)) begin
            len_ext = len_ext | {b, 8'h00};
          end
          len_o = len_ext[LENGTH_WIDTH-1:0];
          if (pos_c >= LENGTH_WIDTH'(3)) begin
            ctx_o.phase = PH_KEY;
          end
        end
        PH_KEY: begin
          ctx_o.phase = (b == KeyBase + {6'd0, mac_slot_i}) ? PH_LEN_MATCH : PH_LEN_SKIP;
        end
        PH_LEN_MATCH: begin
          ctx_o.phase = PH_MAC;
          ctx_o.mac   = '0;
          ctx_o.pair  = '0;
          ctx_o.cig   = '0;
          ctx_o.hn    = '0;
        end
        PH_LEN_SKIP: begin
          ctx_o.rem   = b;
          ctx_o.phase = (b != 8'd0) ? PH_SKIP : PH_KEY;
        end
        PH_SKIP: begin
          ctx_o.rem = rem_dec;
          if (rem_dec == 8'd0) begin
            ctx_o.phase = PH_KEY;
          end
        end
        PH_MAC: begin
          if (ctx_c.cig == 2'd0) begin
            ctx_o.hn  = hex_value(b);
            ctx_o.cig = 2'd1;
          end else if (ctx_c.cig == 2'd1) begin
            ctx_o.mac = ctx_c.mac | (48'(pair_val) << {mac_lane(ctx_c.pair), 3'b000});
            ctx_o.hn  = '0;
            ctx_o.cig = 2'd2;
          end else begin
            // delimiter byte closes the pair
            ctx_o.cig  = 2'd0;
            ctx_o.pair = pair_inc;
            if (pair_inc >= MacPairs) begin
              give       = 1'b1;
              give_found = 1'b1;
              give_mac   = ctx_c.mac;
            end
          end
        end
        default: begin
        end
      endcase

      pos_o = (pos_c != PosMax) ? pos_c + LENGTH_WIDTH'(1) : pos_c;

      end_mac = ctx_o.mac;
      if (ctx_o.cig == 2'd1) begin
        end_mac = ctx_o.mac | (48'({ctx_o.hn, 4'h0}) << {mac_lane(ctx_o.pair), 3'b000});
      end

      if (!give) begin
        if (ctx_o.phase == PH_KEY && pos_o >= len_o) begin
          give = 1'b1;
        end else if (payload_end_i) begin
          give = 1'b1;
          if (ctx_o.phase == PH_MAC) begin
            give_found = 1'b1;
            give_mac   = end_mac;
          end
        end
      end

      if (give) begin
        ctx_o.phase = PH_DONE;
        res_o.valid = 1'b1;
        res_o.found = give_found;
        res_o.mac   = give_found ? give_mac : '0;
      end
    end
  end

endmodule

/* hw/rtl/tlvmp_out_reg.sv */
// ----------------------------------------------------------------------------
// tlvmp_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module tlvmp_out_reg import tlvmp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  tlvmp_res_t  res_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [47:0] mac_address_o
);

  logic        valid_q, valid_d;
  logic        found_q;
  logic [47:0] mac_q;

  // room for a new result when empty or being taken this cycle
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      found_q <= res_i.found;
      mac_q   <= res_i.mac;
    end
  end

  assign out_valid_o   = valid_q;
  assign found_o       = found_q;
  assign mac_address_o = mac_q;

endmodule
